FILE: rtl/erle_pkg.sv
// shared types and constants for the escape run-length encoder
// no dependencies; imported by every module of the block
package erle_pkg;

    localparam logic [7:0] ESC_TOKEN     = 8'hFF;
    localparam logic [7:0] END_COUNT     = 8'h00;
    localparam logic [7:0] LITERAL_LIMIT = 8'd3;
    localparam logic [7:0] MAX_RUN_RESET = 8'd255;
    localparam int         QUEUE_DEPTH   = 4;

    // one finished run waiting to be written out
    typedef struct packed {
        logic       vld;
        logic [7:0] value;
        logic [7:0] len;
    } erle_run_t;

    // work for the back end from one item: closed run, flushed run, terminator
    typedef struct packed {
        erle_run_t run0;
        erle_run_t run1;
        logic      term;
    } erle_cmd_t;

    // queue status used for the input stall and by the back end
    typedef struct packed {
        logic full;
        logic empty;
    } erle_qstat_t;

endpackage

FILE: rtl/erle_front.sv
// front end: run tracking, max run length register, command building
// depends on erle_pkg
module erle_front
    import erle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        end_of_block,
    output logic        push,
    output erle_cmd_t   cmd
);

    logic [7:0] max_run_reg;
    logic [7:0] run_value_reg, run_value_next;
    logic [7:0] run_length_reg, run_length_next;
    logic       run_open_reg, run_open_next;
    logic [7:0] limit;
    logic       extend;
    logic [7:0] mid_value;
    logic [7:0] mid_length;
    logic       mid_open;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_run_reg <= MAX_RUN_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_run_reg <= cfg_wr_data;
        end
    end

    // run update and command for the item
    always_comb
    begin
        limit      = (max_run_reg == 8'd0) ? 8'd1 : max_run_reg;
        extend     = run_open_reg && (data_byte == run_value_reg) && (run_length_reg < limit);
        mid_value  = run_value_reg;
        mid_length = run_length_reg;
        mid_open   = run_open_reg;
        cmd        = '0;
        if (byte_valid)
        begin
            if (extend)
            begin
                mid_length = run_length_reg + 8'd1;
            end
            else
            begin
                cmd.run0.vld   = run_open_reg;
                cmd.run0.value = run_value_reg;
                cmd.run0.len   = run_length_reg;
                mid_value      = data_byte;
                mid_length     = 8'd1;
                mid_open       = 1'b1;
            end
        end
        run_value_next  = mid_value;
        run_length_next = mid_length;
        run_open_next   = mid_open;
        if (end_of_block)
        begin
            cmd.run1.vld    = mid_open;
            cmd.run1.value  = mid_value;
            cmd.run1.len    = mid_length;
            cmd.term        = 1'b1;
            run_value_next  = 8'd0;
            run_length_next = 8'd0;
            run_open_next   = 1'b0;
        end
        push = accept && (cmd.run0.vld || cmd.term);
    end

    // run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_value_reg  <= 8'd0;
            run_length_reg <= 8'd0;
            run_open_reg   <= 1'b0;
        end
        else if (accept)
        begin
            run_value_reg  <= run_value_next;
            run_length_reg <= run_length_next;
            run_open_reg   <= run_open_next;
        end
    end

endmodule

FILE: rtl/erle_queue.sv
// command queue between front and back ends
// depends on erle_pkg
module erle_queue
    import erle_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  erle_cmd_t   push_cmd,
    input  logic        pop,
    output erle_cmd_t   head,
    output erle_qstat_t stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    erle_cmd_t     slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

FILE: rtl/erle_back.sv
// back end: serialises queued commands into output bytes, output register
// depends on erle_pkg
module erle_back
    import erle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  erle_cmd_t   head,
    input  erle_qstat_t stat,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        out_last
);

    logic [2:0] done_reg, done_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic [2:0] remain;
    logic [2:0] cur_bit;
    erle_run_t  cur_run;
    logic       esc;
    logic [1:0] seg_len;
    logic [7:0] byte_now;
    logic       last_now;
    logic       seg_end;
    logic       advance;

    // pick the current segment and its byte
    always_comb
    begin
        remain  = {head.term, head.run1.vld, head.run0.vld} & ~done_reg;
        cur_bit = 3'b100;
        cur_run = head.run1;
        if (remain[0])
        begin
            cur_bit = 3'b001;
            cur_run = head.run0;
        end
        else if (remain[1])
        begin
            cur_bit = 3'b010;
        end
        esc      = (cur_run.value == ESC_TOKEN) || (cur_run.len > LITERAL_LIMIT);
        seg_len  = cur_run.len[1:0];
        byte_now = cur_run.value;
        last_now = 1'b0;
        if (cur_bit[2])
        begin
            seg_len  = 2'd3;
            byte_now = (idx_reg == 2'd2) ? END_COUNT : ESC_TOKEN;
            last_now = (idx_reg == 2'd2);
        end
        else if (esc)
        begin
            seg_len = 2'd3;
            case (idx_reg)
                2'd0:    byte_now = ESC_TOKEN;
                2'd1:    byte_now = cur_run.value;
                default: byte_now = cur_run.len;
            endcase
        end
        seg_end = (idx_reg == seg_len - 2'd1);
        advance = !stat.empty && (!out_valid_reg || !out_stall);
        pop     = advance && seg_end && ((remain & ~cur_bit) == 3'b000);
        done_next = done_reg;
        idx_next  = idx_reg;
        if (advance)
        begin
            if (pop)
            begin
                done_next = 3'b000;
                idx_next  = 2'd0;
            end
            else if (seg_end)
            begin
                done_next = done_reg | cur_bit;
                idx_next  = 2'd0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    // sequencer state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 3'b000;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            idx_reg  <= idx_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= byte_now;
            out_last_reg <= last_now;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

FILE: rtl/escape_rle_encoder_core.sv
// Escape run-length encoder, top level.
// Input channel: in_valid / in_stall with data_byte, byte_valid, end_of_block.
// An item is taken when in_valid is high and in_stall low; one item per cycle
// is taken while the command queue has room.
// Output channel: out_valid / out_stall with out_byte, out_last (set on the
// final terminator byte of a block).
// Configuration: cfg_wr_en / cfg_wr_data write max_run_length (0 acts as 1).
// A run is written as FF, value, length when the value is FF or the length is
// above 3, else as literal bytes; end of block adds FF FF 00.
// Path: an accepted item's command is written into the queue, and its first
// byte then goes from the queue head into the output register.
// Throughput: one output byte per cycle while the queue holds work and
// out_stall is low; an item causes 0 to 9 bytes, so the input rate is set by
// the output byte count and the queue depth (QUEUE_DEPTH commands).
// Reset: max_run_length returns to 255, the run state and queue are emptied.
// While out_stall is high with out_valid set, the output byte holds and the
// back end waits; the front keeps taking items until the queue fills.
// depends on erle_pkg, erle_front, erle_queue, erle_back
module escape_rle_encoder_core
    import erle_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       byte_valid,
    input  logic       end_of_block,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last
);

    erle_qstat_t q_stat;
    erle_cmd_t   push_cmd;
    erle_cmd_t   head;
    logic        push;
    logic        pop;
    logic        accept;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;

    // run tracking
    erle_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .accept       (accept),
        .data_byte    (data_byte),
        .byte_valid   (byte_valid),
        .end_of_block (end_of_block),
        .push         (push),
        .cmd          (push_cmd)
    );

    // command queue
    erle_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    // byte serialiser
    erle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .stat      (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

`ifndef NO_ASSERTIONS
    a_last_is_end_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |-> out_byte == END_COUNT)
        else $error("terminator byte is not the end count");

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reported full and empty together");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("queue popped while empty");
`endif

endmodule
